[rtl/core/aart_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aart_pkg: shared types and constants for the axis-angle transform block
// Item bundles, fixed-point constants, arctangent table and saturation.
// ----------------------------------------------------------------------------
package aart_pkg;

	localparam int MATRIX_DIM_DEF    = 4;
	localparam int CORDIC_STAGES_DEF = 16;
	// power of two, pointers wrap freely
	localparam int QUEUE_DEPTH       = 4;

	// CORDIC x/y width (Q30 plus headroom) and angle accumulator width (Q24 degrees)
	localparam int CW = 33;
	localparam int ZW = 34;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [33:0]   ONE_Q30     = 34'sd1073741824;
	localparam logic signed [31:0]   ONE_Q16     = 32'sd65536;

	// angle limits in Q9.16 degrees, one bit wider than the input field
	localparam logic signed [26:0] DEG360 = 27'sd23592960;
	localparam logic signed [26:0] DEG180 = 27'sd11796480;
	localparam logic signed [26:0] DEG90  = 27'sd5898240;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic signed [15:0] al;
		logic signed [15:0] am;
		logic signed [15:0] an;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sz;
	} geom_t;

	typedef struct packed {
		geom_t              g;
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] s;
	} trig_t;

	// atan(2^-i) in degrees * 2^24, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_q24(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0:  r = 34'sd754974720;
			1:  r = 34'sd445687602;
			2:  r = 34'sd235489088;
			3:  r = 34'sd119537938;
			4:  r = 34'sd60000934;
			5:  r = 34'sd30029717;
			6:  r = 34'sd15018523;
			7:  r = 34'sd7509720;
			8:  r = 34'sd3754917;
			9:  r = 34'sd1877466;
			10: r = 34'sd938734;
			11: r = 34'sd469367;
			12: r = 34'sd234684;
			13: r = 34'sd117342;
			14: r = 34'sd58671;
			15: r = 34'sd29335;
			16: r = 34'sd14668;
			17: r = 34'sd7334;
			18: r = 34'sd3667;
			19: r = 34'sd1833;
			20: r = 34'sd917;
			21: r = 34'sd458;
			22: r = 34'sd229;
			23: r = 34'sd115;
			24: r = 34'sd57;
			25: r = 34'sd29;
			26: r = 34'sd14;
			27: r = 34'sd7;
			28: r = 34'sd4;
			29: r = 34'sd2;
			30: r = 34'sd1;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -48'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/aart_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aart_front: input capture, angle reduction and pipelined CORDIC
// Takes one item per cycle while in_stall is low, folds the angle and delivers cosine and sine.
// ----------------------------------------------------------------------------
module aart_front #(
	parameter int CORDIC_STAGES = aart_pkg::CORDIC_STAGES_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire aart_pkg::geom_t in_geom,
	input  wire signed [25:0]    in_angle,
	output logic                 push_valid,
	input  wire                  push_stall,
	output aart_pkg::trig_t      push_data
);
	localparam int N  = CORDIC_STAGES;
	localparam int CW = aart_pkg::CW;
	localparam int ZW = aart_pkg::ZW;

	logic                 v_s1;
	aart_pkg::geom_t      g_s1;
	logic signed [25:0]   ang_s1;

	logic [N:0]            v_s;
	aart_pkg::geom_t       g_s   [N+1];
	logic signed [CW-1:0]  x_s   [N+1];
	logic signed [CW-1:0]  y_s   [N+1];
	logic signed [ZW-1:0]  z_s   [N+1];
	logic                  neg_s [N+1];

	logic [N:0]            en;
	logic                  en_s1;

	logic signed [26:0]    a_w, m_w, f_w, r_w;
	logic                  neg_w;
	logic signed [ZW-1:0]  z0_w;

	// advance each stage when it is empty or the next one moves
	always_comb begin
		en[N] = !v_s[N] || !push_stall;
		for (int k = N - 1; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
		en_s1 = !v_s1 || en[0];
	end

	assign in_stall = !en_s1;

	// capture the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			g_s1   <= in_geom;
			ang_s1 <= in_angle;
		end
	end

	// wrap to [0, 360), fold to (-180, 180], then to [-90, 90] with a sign flip
	always_comb begin
		a_w = {ang_s1[25], ang_s1};
		if (a_w >= aart_pkg::DEG360)
			m_w = a_w - aart_pkg::DEG360;
		else if (a_w >= 27'sd0)
			m_w = a_w;
		else if (a_w >= -aart_pkg::DEG360)
			m_w = a_w + aart_pkg::DEG360;
		else
			m_w = a_w + aart_pkg::DEG360 + aart_pkg::DEG360;
		f_w = (m_w > aart_pkg::DEG180) ? m_w - aart_pkg::DEG360 : m_w;
		if (f_w > aart_pkg::DEG90) begin
			r_w   = f_w - aart_pkg::DEG180;
			neg_w = 1'b1;
		end else if (f_w < -aart_pkg::DEG90) begin
			r_w   = f_w + aart_pkg::DEG180;
			neg_w = 1'b1;
		end else begin
			r_w   = f_w;
			neg_w = 1'b0;
		end
		z0_w = ZW'({r_w, 8'd0});
	end

	// seed the rotator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en[0]) begin
			v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0] && v_s1) begin
			g_s[0]   <= g_s1;
			x_s[0]   <= aart_pkg::CORDIC_GAIN;
			y_s[0]   <= '0;
			z_s[0]   <= z0_w;
			neg_s[0] <= neg_w;
		end
	end

	// one micro-rotation per stage
	for (genvar k = 1; k <= N; k++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && v_s[k-1]) begin
				g_s[k]   <= g_s[k-1];
				neg_s[k] <= neg_s[k-1];
				if (z_s[k-1] >= 0) begin
					x_s[k] <= x_s[k-1] - (y_s[k-1] >>> (k - 1));
					y_s[k] <= y_s[k-1] + (x_s[k-1] >>> (k - 1));
					z_s[k] <= z_s[k-1] - aart_pkg::atan_q24(k - 1);
				end else begin
					x_s[k] <= x_s[k-1] + (y_s[k-1] >>> (k - 1));
					y_s[k] <= y_s[k-1] - (x_s[k-1] >>> (k - 1));
					z_s[k] <= z_s[k-1] + aart_pkg::atan_q24(k - 1);
				end
			end
		end
	end

	// undo the half-turn fold
	assign push_valid  = v_s[N];
	assign push_data.g = g_s[N];
	assign push_data.c = neg_s[N] ? -x_s[N] : x_s[N];
	assign push_data.s = neg_s[N] ? -y_s[N] : y_s[N];

endmodule
`default_nettype wire

[rtl/core/aart_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aart_fifo: short queue between the front and the back
// Holds items with their cosine and sine until the back takes them.
// ----------------------------------------------------------------------------
module aart_fifo (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push_valid,
	output logic                  push_stall,
	input  wire aart_pkg::trig_t  push_data,
	output logic                  pop_valid,
	input  wire                   pop_stall,
	output aart_pkg::trig_t       pop_data
);
	localparam int D  = aart_pkg::QUEUE_DEPTH;
	localparam int AW = $clog2(D);
	localparam int NW = $clog2(D + 1);

	aart_pkg::trig_t mem [D];
	logic [AW-1:0]   wr_q, rd_q;
	logic [NW-1:0]   cnt_q;
	logic            push, pop;

	assign push_stall = (cnt_q == NW'(D));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_data   = mem[rd_q];

	// track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// store the item
	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

[rtl/core/aart_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aart_back: matrix arithmetic and row sequencer
// Builds rotation terms and translation, then sends the four matrix rows.
// ----------------------------------------------------------------------------
module aart_back #(
	parameter int MATRIX_DIM = aart_pkg::MATRIX_DIM_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  pop_valid,
	output logic                 pop_stall,
	input  wire aart_pkg::trig_t pop_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [1:0]           row_index,
	output logic signed [31:0]   elem_c0,
	output logic signed [31:0]   elem_c1,
	output logic signed [31:0]   elem_c2,
	output logic signed [31:0]   elem_c3,
	output logic                 last_row
);
	localparam int CW = aart_pkg::CW;
	localparam logic [1:0] LAST = 2'(MATRIX_DIM - 1);

	logic [6:1] v_s;
	logic [6:1] en;
	logic       load_ok;

	// stage 1: axis products and 1-c
	aart_pkg::geom_t      g_s1;
	logic signed [CW-1:0] c_s1;
	logic signed [33:0]   omc_s1;
	logic signed [31:0]   pa_s1 [6];
	logic signed [48:0]   ps_s1 [3];
	// stage 2: rounded Q30 terms
	aart_pkg::geom_t      g_s2;
	logic signed [CW-1:0] c_s2;
	logic signed [37:0]   pq_s2 [6];
	logic signed [35:0]   sq_s2 [3];
	// stage 3: rotation elements in Q30
	aart_pkg::geom_t      g_s3;
	logic signed [39:0]   rot_s3 [9];
	// stage 4: output and translation precision
	aart_pkg::geom_t      g_s4;
	logic signed [31:0]   q16_s4 [9];
	logic signed [34:0]   q24_s4 [9];
	// stage 5: element times centre
	aart_pkg::geom_t      g_s5;
	logic signed [31:0]   q16_s5 [9];
	logic signed [66:0]   pr_s5  [9];
	// stage 6: rotated centre in Q16
	aart_pkg::geom_t      g_s6;
	logic signed [31:0]   q16_s6 [9];
	logic signed [44:0]   rr_s6  [3];
	// held matrix
	logic                 mat_v_q;
	logic [1:0]           row_q;
	logic signed [31:0]   rq_q [9];
	logic signed [31:0]   t_q  [3];

	logic signed [15:0]   ax   [3];
	logic signed [31:0]   cen4 [3];
	logic signed [31:0]   cen6 [3];
	logic signed [31:0]   sh6  [3];

	assign ax[0]   = $signed(pop_data.g.al);
	assign ax[1]   = $signed(pop_data.g.am);
	assign ax[2]   = $signed(pop_data.g.an);
	assign cen4[0] = $signed(g_s4.cx);
	assign cen4[1] = $signed(g_s4.cy);
	assign cen4[2] = $signed(g_s4.cz);
	assign cen6[0] = $signed(g_s6.cx);
	assign cen6[1] = $signed(g_s6.cy);
	assign cen6[2] = $signed(g_s6.cz);
	assign sh6[0]  = $signed(g_s6.sx);
	assign sh6[1]  = $signed(g_s6.sy);
	assign sh6[2]  = $signed(g_s6.sz);

	// advance stages, collapsing bubbles
	assign load_ok = !mat_v_q || (!out_stall && row_q == LAST);
	always_comb begin
		en[6] = !v_s[6] || load_ok;
		for (int k = 5; k >= 1; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end
	assign pop_stall = !en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[1]) v_s[1] <= pop_valid;
			for (int k = 2; k <= 6; k++) begin
				if (en[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	// stage 1: ll, mm, nn, lm, ln, mn and l*s, m*s, n*s
	always_ff @(posedge clk) begin
		if (en[1] && pop_valid) begin
			g_s1     <= pop_data.g;
			c_s1     <= pop_data.c;
			omc_s1   <= aart_pkg::ONE_Q30 - 34'(pop_data.c);
			pa_s1[0] <= 32'(ax[0]) * 32'(ax[0]);
			pa_s1[1] <= 32'(ax[1]) * 32'(ax[1]);
			pa_s1[2] <= 32'(ax[2]) * 32'(ax[2]);
			pa_s1[3] <= 32'(ax[0]) * 32'(ax[1]);
			pa_s1[4] <= 32'(ax[0]) * 32'(ax[2]);
			pa_s1[5] <= 32'(ax[1]) * 32'(ax[2]);
			for (int j = 0; j < 3; j++) begin
				ps_s1[j] <= 49'(ax[j]) * 49'(pop_data.s);
			end
		end
	end

	// stage 2: scale by 1-c, round half up
	always_ff @(posedge clk) begin
		logic signed [66:0] t;
		logic signed [49:0] u;
		if (en[2] && v_s[1]) begin
			g_s2 <= g_s1;
			c_s2 <= c_s1;
			for (int j = 0; j < 6; j++) begin
				t = 67'(pa_s1[j]) * 67'(omc_s1);
				pq_s2[j] <= 38'((t + 67'sd134217728) >>> 28);
			end
			for (int j = 0; j < 3; j++) begin
				u = 50'(ps_s1[j]) + 50'sd8192;
				sq_s2[j] <= 36'(u >>> 14);
			end
		end
	end

	// stage 3: Rodrigues sums
	always_ff @(posedge clk) begin
		if (en[3] && v_s[2]) begin
			g_s3      <= g_s2;
			rot_s3[0] <= 40'(pq_s2[0]) + 40'(c_s2);
			rot_s3[1] <= 40'(pq_s2[3]) - 40'(sq_s2[2]);
			rot_s3[2] <= 40'(pq_s2[4]) + 40'(sq_s2[1]);
			rot_s3[3] <= 40'(pq_s2[3]) + 40'(sq_s2[2]);
			rot_s3[4] <= 40'(pq_s2[1]) + 40'(c_s2);
			rot_s3[5] <= 40'(pq_s2[5]) - 40'(sq_s2[0]);
			rot_s3[6] <= 40'(pq_s2[4]) - 40'(sq_s2[1]);
			rot_s3[7] <= 40'(pq_s2[5]) + 40'(sq_s2[0]);
			rot_s3[8] <= 40'(pq_s2[2]) + 40'(c_s2);
		end
	end

	// stage 4: round to Q16 for output and Q24 for translation
	always_ff @(posedge clk) begin
		if (en[4] && v_s[3]) begin
			g_s4 <= g_s3;
			for (int j = 0; j < 9; j++) begin
				q16_s4[j] <= aart_pkg::sat32(48'((rot_s3[j] + 40'sd8192) >>> 14));
				q24_s4[j] <= 35'((rot_s3[j] + 40'sd32) >>> 6);
			end
		end
	end

	// stage 5: multiply by centre coordinates
	always_ff @(posedge clk) begin
		if (en[5] && v_s[4]) begin
			g_s5   <= g_s4;
			q16_s5 <= q16_s4;
			for (int r = 0; r < 3; r++) begin
				for (int j = 0; j < 3; j++) begin
					pr_s5[3*r+j] <= 67'(q24_s4[3*r+j]) * 67'(cen4[j]);
				end
			end
		end
	end

	// stage 6: sum each row and round to Q16
	always_ff @(posedge clk) begin
		logic signed [68:0] acc;
		if (en[6] && v_s[5]) begin
			g_s6   <= g_s5;
			q16_s6 <= q16_s5;
			for (int r = 0; r < 3; r++) begin
				acc = 69'(pr_s5[3*r]) + 69'(pr_s5[3*r+1]) + 69'(pr_s5[3*r+2])
					+ 69'sd8388608;
				rr_s6[r] <= 45'(acc >>> 24);
			end
		end
	end

	// hold the matrix and step through its rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_v_q <= 1'b0;
			row_q   <= '0;
		end else if (load_ok) begin
			mat_v_q <= v_s[6];
			row_q   <= '0;
		end else if (!out_stall) begin
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && v_s[6]) begin
			rq_q <= q16_s6;
			for (int r = 0; r < 3; r++) begin
				t_q[r] <= aart_pkg::sat32(48'(sh6[r]) + 48'(cen6[r]) - 48'(rr_s6[r]));
			end
		end
	end

	// drive the current row
	assign out_valid = mat_v_q;
	assign row_index = row_q;
	assign last_row  = (row_q == LAST);
	always_comb begin
		case (row_q)
			2'd0: begin
				elem_c0 = rq_q[0]; elem_c1 = rq_q[1]; elem_c2 = rq_q[2]; elem_c3 = t_q[0];
			end
			2'd1: begin
				elem_c0 = rq_q[3]; elem_c1 = rq_q[4]; elem_c2 = rq_q[5]; elem_c3 = t_q[1];
			end
			2'd2: begin
				elem_c0 = rq_q[6]; elem_c1 = rq_q[7]; elem_c2 = rq_q[8]; elem_c3 = t_q[2];
			end
			default: begin
				elem_c0 = '0; elem_c1 = '0; elem_c2 = '0; elem_c3 = aart_pkg::ONE_Q16;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/axis_angle_rigid_transform_matrix.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_rigid_transform_matrix: rotation about an axis through a point
// Builds the homogeneous 4x4 matrix of a rotation plus shift per item.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) takes one item: centre, axis
//   cosines, shift and angle. The output channel (out_valid / out_stall)
//   returns four row items per input, row_index 0..3, last_row on row 3.
//   From acceptance to row 0 on the output an item passes the capture
//   register, the angle fold into the rotator seed, the CORDIC stages,
//   the queue, six arithmetic stages and the row register.
//   The single row output sends one row per cycle while out_stall is low,
//   so a new matrix loads only after its last row is taken; the front
//   takes an item each cycle until the back stages, the queue and the
//   front pipeline fill, which takes about CORDIC_STAGES + 13 items.
//   Reset clears all valid flags and the queue; no item is in flight after.
//   When the receiver stalls, the current row holds, the back stages fill,
//   then the queue, then the front, and finally in_stall rises.
// ----------------------------------------------------------------------------
module axis_angle_rigid_transform_matrix #(
	parameter int MATRIX_DIM    = aart_pkg::MATRIX_DIM_DEF,
	parameter int CORDIC_STAGES = aart_pkg::CORDIC_STAGES_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire signed [31:0]  centre_x,
	input  wire signed [31:0]  centre_y,
	input  wire signed [31:0]  centre_z,
	input  wire signed [15:0]  axis_l,
	input  wire signed [15:0]  axis_m,
	input  wire signed [15:0]  axis_n,
	input  wire signed [31:0]  shift_x,
	input  wire signed [31:0]  shift_y,
	input  wire signed [31:0]  shift_z,
	input  wire signed [25:0]  angle_deg,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [1:0]         row_index,
	output logic signed [31:0] elem_c0,
	output logic signed [31:0] elem_c1,
	output logic signed [31:0] elem_c2,
	output logic signed [31:0] elem_c3,
	output logic               last_row
);
	aart_pkg::geom_t in_geom;
	aart_pkg::trig_t push_data, pop_data;
	logic            push_valid, push_stall, pop_valid, pop_stall;

	assign in_geom = '{cx: centre_x, cy: centre_y, cz: centre_z,
		al: axis_l, am: axis_m, an: axis_n,
		sx: shift_x, sy: shift_y, sz: shift_z};

	aart_front #(.CORDIC_STAGES(CORDIC_STAGES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_geom    (in_geom),
		.in_angle   (angle_deg),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_data  (push_data)
	);

	aart_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_data   (pop_data)
	);

	aart_back #(.MATRIX_DIM(MATRIX_DIM)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_stall (pop_stall),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.row_index (row_index),
		.elem_c0   (elem_c0),
		.elem_c1   (elem_c1),
		.elem_c2   (elem_c2),
		.elem_c3   (elem_c3),
		.last_row  (last_row)
	);

	// a row taken before the last is followed by the next row of the same matrix
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_row |=>
			out_valid && (row_index == $past(row_index) + 2'd1))
		else $error("row sequence broken");

	// a new matrix always starts at row 0
	a_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_row |=> !out_valid || (row_index == 2'd0))
		else $error("matrix does not start at row 0");

	// the final flag marks row 3 and only row 3
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_row == (row_index == 2'd3)))
		else $error("last_row flag mismatch");

endmodule
`default_nettype wire
